FILE: rtl/core/zht_pkg.sv
// Package with shared types and constants for the zone hit tester.
`default_nettype none
package zht_pkg;
   localparam int MaxZonesDefault  = 16;
   localparam int CoordBitsDefault = 16;
   localparam logic [7:0] RadiusReset = 8'd20;

   localparam logic [1:0] CmdClear  = 2'd0;
   localparam logic [1:0] CmdAppend = 2'd1;
   localparam logic [1:0] CmdQuery  = 2'd2;
   localparam logic [1:0] CmdUnused = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic signed [15:0] rect_left;
      logic signed [15:0] rect_top;
      logic signed [15:0] rect_right;
      logic signed [15:0] rect_bottom;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
   } req_type;

   typedef struct packed {
      logic [3:0] zone_index;
      logic       hit;
      logic       chose_smallest;
      logic       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic append;
      logic load_point;
      logic scan_start;
      logic scan_step;
      logic pair_start;
      logic pair_step;
      logic emit_start;
      logic emit_step;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic pair_done;
      logic emit_done;
      logic empty_answer;
      logic overlap;
   } sts_type;
endpackage
`default_nettype wire

FILE: rtl/core/zht_ctrl.sv
// Controller state machine that sequences clear, append and query requests.
`default_nettype none
module zht_ctrl
   import zht_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic [1:0] req_command,
   output logic         req_stall,
   input  wire logic    out_free,
   output ctl_type      ctl,
   input  wire sts_type sts
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_PAIR = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_WAIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.clear      = (req_command == CmdClear);
               ctl.append     = (req_command == CmdAppend);
               if (req_command == CmdQuery) begin
                  ctl.load_point = 1'b1;
                  ctl.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               ctl.pair_start = 1'b1;
               state_in       = ST_PAIR;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         ST_PAIR: begin
            if (sts.pair_done || sts.overlap || sts.empty_answer) begin
               ctl.emit_start = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               ctl.pair_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ctl.emit_step = 1'b1;
               if (sts.emit_done) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/zht_datapath.sv
// Datapath with the zone memory, capture scan, overlap search, area compare and result output.
`default_nettype none
module zht_datapath
   import zht_pkg::*;
#(
   parameter int MAX_ZONES  = MaxZonesDefault,
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire logic [7:0] radius,
   input  wire ctl_type ctl,
   output sts_type      sts,
   output logic         out_free,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int IW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int CW = $clog2(MAX_ZONES + 1);
   localparam int EW = COORD_BITS + 2;
   localparam int AW = 2 * (COORD_BITS + 1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] l;
      logic signed [COORD_BITS-1:0] t;
      logic signed [COORD_BITS-1:0] r;
      logic signed [COORD_BITS-1:0] b;
   } zone_type;

   zone_type mem [MAX_ZONES];
   zone_type rd_ff;
   logic [IW-1:0] raddr;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] scan_ff;
   logic          scan_val_ff;
   logic [IW-1:0] scan_idx_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic [MAX_ZONES-1:0] cap_ff;
   logic [CW-1:0] ncap_ff;
   logic          strict_ff;

   logic [IW-1:0] pi_ff, pj_ff;
   logic          pphase_ff;
   zone_type      za_ff;
   logic          pvalid_ff;
   logic          overlap_ff;
   logic          pdone_ff;

   logic [AW-1:0] best_area_ff;
   logic [IW-1:0] best_ff;
   logic          best_any_ff;
   logic [CW-1:0] emit_ff;

   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic signed [COORD_BITS-1:0] crd(input logic signed [15:0] v);
      logic [COORD_BITS-1:0] e;
      e = COORD_BITS'(unsigned'(v));
      if (COORD_BITS > 16) begin
         e = COORD_BITS'(signed'(v[15:0]));
      end
      return signed'(e);
   endfunction

   // Memory address mux: scan index, pair read index or the area pass index.
   always_comb begin
      raddr = emit_ff[IW-1:0];
      if (ctl.scan_step) begin
         raddr = scan_ff[IW-1:0];
      end
      if (ctl.pair_start || ctl.pair_step) begin
         raddr = pphase_ff ? pj_ff : pi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.append && (count_ff < CW'(MAX_ZONES))) begin
         mem[count_ff[IW-1:0]] <= '{crd(req_data.rect_left), crd(req_data.rect_top),
                                   crd(req_data.rect_right), crd(req_data.rect_bottom)};
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.clear) begin
         count_ff <= '0;
      end else if (ctl.append && (count_ff < CW'(MAX_ZONES))) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Capture test on the registered memory read.
   logic signed [EW-1:0] el, et, er, eb, ex, ey, rr;
   logic                 proper, capt, strict;
   always_comb begin
      rr = EW'(radius);
      el = EW'(rd_ff.l);
      et = EW'(rd_ff.t);
      er = EW'(rd_ff.r);
      eb = EW'(rd_ff.b);
      ex = EW'(px_ff);
      ey = EW'(py_ff);
      proper = (rd_ff.l < rd_ff.r) && (rd_ff.t < rd_ff.b);
      capt = proper && (el - rr <= ex) && (ex <= er + rr)
             && (et - rr <= ey) && (ey <= eb + rr);
      strict = proper && (rd_ff.l <= px_ff) && (px_ff < rd_ff.r)
               && (rd_ff.t <= py_ff) && (py_ff < rd_ff.b);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_point) begin
         px_ff <= crd(req_data.point_x);
         py_ff <= crd(req_data.point_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         scan_val_ff <= 1'b0;
         cap_ff      <= '0;
         ncap_ff     <= '0;
         strict_ff   <= 1'b0;
         scan_idx_ff <= '0;
      end else if (ctl.scan_start) begin
         scan_ff     <= '0;
         scan_val_ff <= 1'b0;
         cap_ff      <= '0;
         ncap_ff     <= '0;
         strict_ff   <= 1'b0;
      end else if (ctl.scan_step) begin
         scan_val_ff <= (scan_ff < count_ff);
         scan_idx_ff <= scan_ff[IW-1:0];
         if (scan_ff < count_ff) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (scan_val_ff) begin
            cap_ff[scan_idx_ff] <= capt;
            ncap_ff             <= ncap_ff + CW'(capt);
            strict_ff           <= strict_ff | strict;
         end
      end
   end

   assign sts.scan_done = !scan_val_ff && (scan_ff >= count_ff);
   assign sts.empty_answer = (ncap_ff == '0) || ((ncap_ff == CW'(1)) && !strict_ff);

   // Pair search: for each captured i, read zone i, then read each j>i and test the captured ones.
   logic signed [COORD_BITS-1:0] mt, mb, ml, mr;
   logic ovl;
   always_comb begin
      mt  = (za_ff.t > rd_ff.t) ? za_ff.t : rd_ff.t;
      mb  = (za_ff.b < rd_ff.b) ? za_ff.b : rd_ff.b;
      ml  = (za_ff.l > rd_ff.l) ? za_ff.l : rd_ff.l;
      mr  = (za_ff.r < rd_ff.r) ? za_ff.r : rd_ff.r;
      ovl = (mt < mb) && (ml < mr);
   end

   logic pv_is_a_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pi_ff <= '0; pj_ff <= '0; pphase_ff <= 1'b0; pvalid_ff <= 1'b0;
         overlap_ff <= 1'b0; pdone_ff <= 1'b0; pv_is_a_ff <= 1'b0;
      end else if (ctl.pair_start) begin
         pi_ff <= '0; pj_ff <= '0; pphase_ff <= 1'b0; pvalid_ff <= 1'b0;
         overlap_ff <= 1'b0; pdone_ff <= 1'b0; pv_is_a_ff <= 1'b0;
      end else if (ctl.pair_step) begin
         // Issue: phase 0 reads zone i, phase 1 reads zone j.
         pvalid_ff  <= 1'b0;
         pv_is_a_ff <= !pphase_ff;
         if (!pphase_ff) begin
            if (!cap_ff[pi_ff]) begin
               if (32'(pi_ff) == MAX_ZONES - 1) pdone_ff <= 1'b1;
               else pi_ff <= pi_ff + 1'b1;
            end else if (32'(pi_ff) == MAX_ZONES - 1) begin
               pdone_ff <= 1'b1;
            end else begin
               pvalid_ff <= 1'b1;
               pphase_ff <= 1'b1;
               pj_ff     <= pi_ff + 1'b1;
            end
         end else begin
            pvalid_ff <= cap_ff[pj_ff];
            if (32'(pj_ff) == MAX_ZONES - 1) begin
               pphase_ff <= 1'b0;
               pi_ff     <= pi_ff + 1'b1;
            end else begin
               pj_ff <= pj_ff + 1'b1;
            end
         end
         if (pvalid_ff) begin
            if (pv_is_a_ff) za_ff <= rd_ff;
            else if (ovl) overlap_ff <= 1'b1;
         end
      end
   end
   assign sts.pair_done = pdone_ff && !pvalid_ff;
   assign sts.overlap   = overlap_ff;

   // Emission: overlap runs an area scan of captured zones, empty sends one miss, else lists them.
   logic [COORD_BITS:0] wdt, hgt;
   logic [AW-1:0] area_ff;
   logic          area_val_ff, area_val2_ff;
   logic [IW-1:0] area_idx_ff, area_idx2_ff;
   assign wdt = (COORD_BITS+1)'(rd_ff.r) - (COORD_BITS+1)'(rd_ff.l);
   assign hgt = (COORD_BITS+1)'(rd_ff.b) - (COORD_BITS+1)'(rd_ff.t);

   logic emit_mode_ovl_ff, emit_mode_empty_ff, final_out;
   logic [CW-1:0] listed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= '0; best_any_ff <= 1'b0; area_val_ff <= 1'b0; area_val2_ff <= 1'b0;
         emit_mode_ovl_ff <= 1'b0; emit_mode_empty_ff <= 1'b0;
         listed_ff <= '0; best_ff <= '0;
      end else if (ctl.emit_start) begin
         emit_ff <= '0; best_any_ff <= 1'b0; area_val_ff <= 1'b0; area_val2_ff <= 1'b0;
         listed_ff <= '0;
         emit_mode_ovl_ff   <= overlap_ff && !sts.empty_answer;
         emit_mode_empty_ff <= sts.empty_answer;
      end else begin
         // Area pipeline runs in overlap mode: read, multiply, compare.
         if (emit_mode_ovl_ff && (emit_ff < CW'(MAX_ZONES))) begin
            emit_ff <= emit_ff + 1'b1;
         end
         area_val_ff  <= emit_mode_ovl_ff && (emit_ff < CW'(MAX_ZONES))
                         && cap_ff[emit_ff[IW-1:0]];
         area_idx_ff  <= emit_ff[IW-1:0];
         area_val2_ff <= area_val_ff;
         area_idx2_ff <= area_idx_ff;
         area_ff      <= wdt * hgt;
         if (area_val2_ff && (!best_any_ff || area_ff <= best_area_ff)) begin
            best_any_ff  <= 1'b1;
            best_area_ff <= area_ff;
            best_ff      <= area_idx2_ff;
         end
         if (ctl.emit_step && !emit_mode_ovl_ff && !emit_mode_empty_ff) begin
            emit_ff <= emit_ff + 1'b1;
            if (cap_ff[emit_ff[IW-1:0]]) listed_ff <= listed_ff + 1'b1;
         end
      end
   end

   logic ovl_ready;
   assign ovl_ready = emit_mode_ovl_ff && (emit_ff >= CW'(MAX_ZONES))
                      && !area_val_ff && !area_val2_ff;
   assign final_out = (listed_ff + CW'(1) == ncap_ff);
   assign sts.emit_done = emit_mode_empty_ff ? 1'b1 :
                          emit_mode_ovl_ff ? ovl_ready :
                          ((emit_ff >= CW'(MAX_ZONES) - CW'(1))
                           || (cap_ff[emit_ff[IW-1:0]] && final_out));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (ctl.emit_step) begin
            if (emit_mode_empty_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{4'd0, 1'b0, 1'b0, 1'b1};
            end else if (emit_mode_ovl_ff) begin
               if (ovl_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{4'(best_ff), 1'b1, 1'b1, 1'b1};
               end
            end else if (cap_ff[emit_ff[IW-1:0]]) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{4'(emit_ff[IW-1:0]), 1'b1, 1'b0, final_out};
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/zone_hit_test_point.sv
// Top level of the zone hit tester with request, response and register ports.
`default_nettype none
// A query scans the zone table one entry per cycle, then checks captured pairs
// with one memory read per cycle, stopping early on an overlap or an empty
// answer. It then sends a single miss response for an empty answer, steps
// through the zones one per cycle while the response is not stalled to list
// the captured ones, or runs an area pass over the captured zones. The zone
// memory has one read port. Results leave through a registered response stage;
// the register write is taken at any time.
module zone_hit_test_point
   import zht_pkg::*;
#(
   parameter int MAX_ZONES  = MaxZonesDefault,
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [7:0] csr_data
);
   logic [7:0] radius_ff;
   ctl_type    ctl;
   sts_type    sts;
   logic       out_free;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusReset;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   zht_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .ctl         (ctl),
      .sts         (sts)
   );

   zht_datapath #(
      .MAX_ZONES  (MAX_ZONES),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .radius    (radius_ff),
      .ctl       (ctl),
      .sts       (sts),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire
